### hw/rtl/sha_pkg.sv
`default_nettype none

package sha_pkg;

    localparam int ROUND_CNT = 64;
    localparam int WORD_CNT  = 8;
    localparam int BLOCK_BYTES = 64;
    localparam int LEN_START = 56;

    localparam logic       FUNC_ABSORB = 1'b0;
    localparam logic       FUNC_FINISH = 1'b1;
    localparam logic [7:0] PAD_BYTE    = 8'h80;

    typedef logic [WORD_CNT-1:0][31:0] t_words;

    typedef struct packed {
        logic start;
        logic init;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    function automatic logic [31:0] sha_iv(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sha_k(input logic [5:0] idx);
        logic [31:0] v;
        case (idx)
            6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;
            default: v = 32'hc67178f2;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sha_core.sv
`default_nettype none

module sha_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sha_pkg::t_core_ctl i_ctl,
    input  wire logic [511:0]       i_block,
    output sha_pkg::t_core_sts      o_sts,
    output sha_pkg::t_words         o_hash
);
    import sha_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    t_words           r_h;
    t_words           r_v;
    logic [15:0][31:0] r_w;
    logic [6:0]       r_rnd;
    logic             r_busy;
    logic             r_done;

    logic [31:0] t1, t2, s0, s1, w_new;

    always_comb begin
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + sha_k(r_rnd[5:0]) + r_w[0];
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
    end

    // Control state and the chaining words, which restart at the initial hash.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
            for (int i = 0; i < WORD_CNT; i++) r_h[i] <= sha_iv(3'(i));
        end else begin
            r_done <= 1'b0;
            if (i_ctl.init) begin
                for (int i = 0; i < WORD_CNT; i++) r_h[i] <= sha_iv(3'(i));
            end else if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                if (r_rnd == 7'(ROUND_CNT)) begin
                    for (int i = 0; i < WORD_CNT; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_rnd <= r_rnd + 7'd1;
                end
            end
        end
    end

    // Working variables and the sixteen-word schedule window.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_v <= r_h;
            for (int j = 0; j < 16; j++) r_w[j] <= i_block[511-32*j -: 32];
        end else if (r_busy && r_rnd != 7'(ROUND_CNT)) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            for (int j = 0; j < 15; j++) r_w[j] <= r_w[j+1];
            r_w[15] <= w_new;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_hash     = r_h;

endmodule

`default_nettype wire

### hw/rtl/sha256_stream_hasher.sv
`default_nettype none

// Streaming SHA-256 hasher. Each input beat either absorbs one message byte
// (i_func = 0) or finishes the message (i_func = 1), after which eight output
// beats carry the digest words, word 0 first, and the hasher is ready for a new
// message. An absorbed byte goes into the block buffer, except that every 64th
// byte also runs the compression unit, one round per cycle, in these steps:
// start, 64 rounds, chaining add, hand back. A finish shifts in the padding
// and length one byte per cycle outside the compressions (9 to 72 bytes, up to
// two compressions) before the eight digest beats. The ready output is low
// while any of this is in progress.
module sha256_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);
    import sha_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAIT = 2'd1;
    localparam logic [1:0] S_PAD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]   r_state;
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;
    logic [63:0]  r_len;
    logic [511:0] r_blk;
    logic         r_pad;
    logic         r_lenmode;
    logic         r_first;
    logic         r_kick;
    logic [2:0]   r_idx;

    logic [5:0]   n_fill;
    logic         in_acc;
    logic         out_acc;
    logic         shift_en;
    logic [7:0]   shift_byte;
    t_core_ctl    core_ctl;
    t_core_sts    core_sts;
    t_words       hash;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign n_fill  = r_fill + 6'd1;

    assign shift_en = (in_acc && i_func == FUNC_ABSORB) || (r_state == S_PAD);

    always_comb begin
        if (r_state != S_PAD) begin
            shift_byte = i_data_byte;
        end else if (r_first) begin
            shift_byte = PAD_BYTE;
        end else if (r_lenmode) begin
            shift_byte = r_len[63:56];
        end else begin
            shift_byte = 8'h00;
        end
    end

    assign core_ctl.start = r_kick;
    assign core_ctl.init  = out_acc && (r_idx == 3'(WORD_CNT - 1));

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_block (r_blk),
        .o_sts   (core_sts),
        .o_hash  (hash)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_bits    <= '0;
            r_pad     <= 1'b0;
            r_lenmode <= 1'b0;
            r_first   <= 1'b0;
            r_kick    <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_kick <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_func == FUNC_ABSORB) begin
                            r_fill <= n_fill;
                            r_bits <= r_bits + 64'd8;
                            if (n_fill == '0) begin
                                r_state <= S_WAIT;
                                r_kick  <= 1'b1;
                            end
                        end else begin
                            r_bits    <= '0;
                            r_pad     <= 1'b1;
                            r_first   <= 1'b1;
                            r_lenmode <= 1'b0;
                            r_state   <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_first <= 1'b0;
                    r_fill  <= n_fill;
                    if (n_fill == '0) begin
                        r_state <= S_WAIT;
                        r_kick  <= 1'b1;
                    end else if (!r_lenmode && n_fill == 6'(LEN_START)) begin
                        // The last eight bytes of the block carry the length.
                        r_lenmode <= 1'b1;
                    end
                end
                S_WAIT: begin
                    if (core_sts.done && !r_kick) begin
                        if (!r_pad) begin
                            r_state <= S_IDLE;
                        end else if (r_lenmode) begin
                            r_state <= S_OUT;
                            r_idx   <= '0;
                        end else begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'(WORD_CNT - 1)) begin
                            r_state   <= S_IDLE;
                            r_pad     <= 1'b0;
                            r_lenmode <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Block buffer as a byte shift line: the first byte of a block ends up on top.
    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            r_blk <= {r_blk[503:0], shift_byte};
        end
        if (in_acc && i_func == FUNC_FINISH) begin
            r_len <= r_bits;
        end else if (r_state == S_PAD && r_lenmode) begin
            r_len <= {r_len[55:0], 8'h00};
        end
    end

    assign o_digest_word = hash[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'(WORD_CNT - 1));

    a_done_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_sts.done |-> r_state == S_WAIT)
        else $error("compression finished outside the wait state");

    a_no_input_during_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input and output sides open at once");

    a_digest_on_block_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> r_fill == '0)
        else $error("digest beats with a partly filled block");

    a_kick_starts_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kick |=> core_sts.busy)
        else $error("compression start did not take");

endmodule

`default_nettype wire
